// File: rtl/core/lpre_pkg.sv
// ----------------------------------------------------------------------------
// lpre_pkg
// Shared types and codes of the LED pattern register engine: request and
// result words, request codes, ring operations and the control bundle
// between controller and datapath.
// ----------------------------------------------------------------------------
package lpre_pkg;

	// request codes
	localparam logic [3:0] REQ_FILL      = 4'd0;
	localparam logic [3:0] REQ_RAMP_UP   = 4'd1;
	localparam logic [3:0] REQ_RAMP_DOWN = 4'd2;
	localparam logic [3:0] REQ_TRIANGLE  = 4'd3;
	localparam logic [3:0] REQ_ROT_R     = 4'd4;
	localparam logic [3:0] REQ_ROT_L     = 4'd5;
	localparam logic [3:0] REQ_SHIFT_R   = 4'd6;
	localparam logic [3:0] REQ_SHIFT_L   = 4'd7;
	localparam logic [3:0] REQ_MIRROR    = 4'd8;
	localparam logic [3:0] REQ_READ      = 4'd9;

	localparam logic [7:0] PEAK_LEVEL_RST = 8'd255;

	typedef struct packed {
		logic [3:0] req_type;
		logic [7:0] new_level;
		logic [3:0] led_index;
	} req_t;

	typedef struct packed {
		logic [7:0] shifted_out;
		logic [7:0] leftmost_level;
		logic [7:0] rightmost_level;
		logic [7:0] read_level;
	} res_t;

	typedef enum logic [2:0] {
		RING_HOLD,
		RING_FILL,
		RING_ROT_R,
		RING_ROT_L,
		RING_SHR,
		RING_SHL,
		RING_MIRROR
	} ring_op_t;

	typedef struct packed {
		ring_op_t ring_op;
		logic     load_req;
		logic     cnt_clr;
		logic     cnt_inc;
		logic     scale_issue;
		logic     read_step;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic scale_busy;
	} sts_t;

endpackage

// File: rtl/core/lpre_scaler.sv
// ----------------------------------------------------------------------------
// lpre_scaler
// Three-stage scaler: level = floor(num * max / LED_COUNT). Divide by the
// constant LED count through a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module lpre_scaler #(
	parameter int LED_COUNT = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         issue,
	input  logic [$clog2(LED_COUNT)-1:0] num,
	input  logic [7:0]                   max_level,
	output logic                         lvl_valid,
	output logic [7:0]                   lvl,
	output logic                         busy
);

	localparam int CW    = $clog2(LED_COUNT);
	localparam int XW    = CW + 8;
	localparam int SH    = XW;
	localparam int RECIP = (1 << SH) / LED_COUNT;

	logic          v_s1, v_s2, v_s3;
	logic [XW-1:0] x_s1, x_s2;
	logic [7:0]    q0_s2;
	logic [7:0]    lvl_s3;

	logic [2*XW-1:0] prod;
	logic [XW-1:0]   qn;
	logic [XW-1:0]   rem;
	logic            corr;

	assign prod = (2*XW)'(x_s1) * (2*XW)'(RECIP);
	assign qn   = XW'(q0_s2) * XW'(LED_COUNT);
	assign rem  = x_s2 - qn;
	// estimate is short by at most one
	assign corr = rem >= XW'(LED_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= XW'(num) * XW'(max_level);
		x_s2   <= x_s1;
		q0_s2  <= prod[SH+7:SH];
		lvl_s3 <= q0_s2 + 8'(corr);
	end

	assign lvl_valid = v_s3;
	assign lvl       = lvl_s3;
	assign busy      = v_s1 | v_s2 | v_s3;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> ##3 lvl_valid)
		else $error("scaler result missing three cycles after issue");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid |-> lvl <= max_level)
		else $error("scaled level above max intensity");

endmodule

// File: rtl/core/lpre_datapath.sv
// ----------------------------------------------------------------------------
// lpre_datapath
// LED level ring, request and result registers, LED counter, max intensity
// register and the shared scaler.
// ----------------------------------------------------------------------------
module lpre_datapath #(
	parameter int LED_COUNT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lpre_pkg::req_t  req_word,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data,
	input  lpre_pkg::cmd_t  cmd,
	output lpre_pkg::sts_t  sts,
	output lpre_pkg::res_t  res_word
);

	localparam int CW   = $clog2(LED_COUNT);
	localparam int IW   = (CW > 4) ? CW : 4;
	localparam int HALF = LED_COUNT / 2;

	logic [7:0]     ring_q [LED_COUNT];
	lpre_pkg::req_t req_q;
	lpre_pkg::res_t res_q;
	logic [7:0]     max_q;
	logic [CW-1:0]  cnt_q;
	logic [7:0]     shift_q;
	logic [7:0]     read_q;

	logic [CW-1:0] k_down;
	logic [CW-1:0] num;
	logic          lvl_v;
	logic [7:0]    lvl;
	logic          scale_busy;

	// numerator of the LED under the counter
	assign k_down = CW'(LED_COUNT - 1) - cnt_q;

	always_comb begin
		case (req_q.req_type)
			lpre_pkg::REQ_RAMP_DOWN: num = k_down;
			lpre_pkg::REQ_TRIANGLE:  num = (cnt_q < CW'(HALF)) ? (cnt_q << 1) : (k_down << 1);
			default:                 num = cnt_q;
		endcase
	end

	lpre_scaler #(
		.LED_COUNT (LED_COUNT)
	) u_scaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (cmd.scale_issue),
		.num       (num),
		.max_level (max_q),
		.lvl_valid (lvl_v),
		.lvl       (lvl),
		.busy      (scale_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= lpre_pkg::PEAK_LEVEL_RST;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// ring: scaler output shifts in at the last LED
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LED_COUNT; k++) ring_q[k] <= '0;
		end else if (lvl_v) begin
			for (int k = 0; k < LED_COUNT - 1; k++) ring_q[k] <= ring_q[k+1];
			ring_q[LED_COUNT-1] <= lvl;
		end else begin
			unique case (cmd.ring_op)
				lpre_pkg::RING_FILL: begin
					for (int k = 0; k < LED_COUNT; k++) ring_q[k] <= req_q.new_level;
				end
				lpre_pkg::RING_ROT_R: begin
					for (int k = 1; k < LED_COUNT; k++) ring_q[k] <= ring_q[k-1];
					ring_q[0] <= ring_q[LED_COUNT-1];
				end
				lpre_pkg::RING_ROT_L: begin
					for (int k = 0; k < LED_COUNT - 1; k++) ring_q[k] <= ring_q[k+1];
					ring_q[LED_COUNT-1] <= ring_q[0];
				end
				lpre_pkg::RING_SHR: begin
					for (int k = 1; k < LED_COUNT; k++) ring_q[k] <= ring_q[k-1];
					ring_q[0] <= req_q.new_level;
				end
				lpre_pkg::RING_SHL: begin
					for (int k = 0; k < LED_COUNT - 1; k++) ring_q[k] <= ring_q[k+1];
					ring_q[LED_COUNT-1] <= req_q.new_level;
				end
				lpre_pkg::RING_MIRROR: begin
					for (int k = 0; k < LED_COUNT; k++) ring_q[k] <= ring_q[LED_COUNT-1-k];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q   <= req_word;
			shift_q <= '0;
			read_q  <= '0;
		end else begin
			if (cmd.ring_op == lpre_pkg::RING_SHR) shift_q <= ring_q[LED_COUNT-1];
			if (cmd.ring_op == lpre_pkg::RING_SHL) shift_q <= ring_q[0];
			// the LED under the counter sits at the head while reading
			if (cmd.read_step && (IW'(cnt_q) == IW'(req_q.led_index))) read_q <= ring_q[0];
		end
		if (cmd.emit) begin
			res_q.shifted_out     <= shift_q;
			res_q.leftmost_level  <= ring_q[0];
			res_q.rightmost_level <= ring_q[LED_COUNT-1];
			res_q.read_level      <= read_q;
		end
	end

	assign sts.cnt_last   = cnt_q == CW'(LED_COUNT - 1);
	assign sts.scale_busy = scale_busy;
	assign res_word       = res_q;

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_v |-> (cmd.ring_op == lpre_pkg::RING_HOLD) && !cmd.emit)
		else $error("scaler write collides with another ring update");

endmodule

// File: rtl/core/lpre_ctrl.sv
// ----------------------------------------------------------------------------
// lpre_ctrl
// Request sequencer: decodes the request, steps the datapath through the
// operation and hands the result word to the output register.
// ----------------------------------------------------------------------------
module lpre_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic [3:0]     req_type,
	output logic           req_stall,
	output logic           res_valid,
	input  logic           res_stall,
	input  lpre_pkg::sts_t sts,
	output lpre_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ONE,
		ST_ISSUE,
		ST_DRAIN,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t             state_q;
	lpre_pkg::ring_op_t ring_op_q;
	logic               res_valid_q;
	logic               out_free;

	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		cmd             = '0;
		cmd.ring_op     = lpre_pkg::RING_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_req = req_valid;
				cmd.cnt_clr  = req_valid;
			end
			ST_ONE: begin
				cmd.ring_op = ring_op_q;
			end
			ST_ISSUE: begin
				cmd.scale_issue = 1'b1;
				cmd.cnt_inc     = 1'b1;
			end
			ST_READ: begin
				cmd.ring_op   = lpre_pkg::RING_ROT_L;
				cmd.read_step = 1'b1;
				cmd.cnt_inc   = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ring_op_q   <= lpre_pkg::RING_HOLD;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						unique case (req_type) inside
							lpre_pkg::REQ_RAMP_UP, lpre_pkg::REQ_RAMP_DOWN,
							lpre_pkg::REQ_TRIANGLE: begin
								state_q <= ST_ISSUE;
							end
							lpre_pkg::REQ_READ: begin
								state_q <= ST_READ;
							end
							lpre_pkg::REQ_FILL: begin
								ring_op_q <= lpre_pkg::RING_FILL;
								state_q   <= ST_ONE;
							end
							lpre_pkg::REQ_ROT_R: begin
								ring_op_q <= lpre_pkg::RING_ROT_R;
								state_q   <= ST_ONE;
							end
							lpre_pkg::REQ_ROT_L: begin
								ring_op_q <= lpre_pkg::RING_ROT_L;
								state_q   <= ST_ONE;
							end
							lpre_pkg::REQ_SHIFT_R: begin
								ring_op_q <= lpre_pkg::RING_SHR;
								state_q   <= ST_ONE;
							end
							lpre_pkg::REQ_SHIFT_L: begin
								ring_op_q <= lpre_pkg::RING_SHL;
								state_q   <= ST_ONE;
							end
							lpre_pkg::REQ_MIRROR: begin
								ring_op_q <= lpre_pkg::RING_MIRROR;
								state_q   <= ST_ONE;
							end
							default: begin
								ring_op_q <= lpre_pkg::RING_HOLD;
								state_q   <= ST_ONE;
							end
						endcase
					end
				end
				ST_ONE: begin
					state_q <= ST_EMIT;
				end
				ST_ISSUE: begin
					if (sts.cnt_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!sts.scale_busy) state_q <= ST_EMIT;
				end
				ST_READ: begin
					if (sts.cnt_last) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!res_valid || !res_stall))
		else $error("result word overwritten while stalled");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> res_valid && (state_q == ST_IDLE))
		else $error("emitted word not presented");

endmodule

// File: rtl/core/led_pattern_register_engine.sv
// ----------------------------------------------------------------------------
// led_pattern_register_engine
// LED intensity array with fill, ramp, triangle, rotate, shift, mirror and
// read requests; one result word per request word.
// ----------------------------------------------------------------------------
// The engine keeps LED_COUNT intensity bytes, all zero after reset, and
// works on one request word at a time; every request returns exactly one
// result word with the first and last LED levels after the operation.
// Sequencing: fill, rotate, shift, mirror and unused codes apply one ring
// operation and then emit the result; a read rotates the ring of levels
// once past its single head tap; ramp and triangle loads feed one LED
// level per cycle through the shared three-stage scaler and then wait
// for its drain. The result sits in an output register, so the next
// request word is taken while the previous result still waits.
// The peak level register is written through cfg_we/cfg_data (reset 255);
// write it only while the engine is idle. A read at an index beyond the
// array returns zero.
// ----------------------------------------------------------------------------
module led_pattern_register_engine #(
	parameter int LED_COUNT = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	// request channel
	input  logic           req_valid,
	output logic           req_stall,
	input  lpre_pkg::req_t req_word,
	// result channel
	output logic           res_valid,
	input  logic           res_stall,
	output lpre_pkg::res_t res_word,
	// max intensity register
	input  logic           cfg_we,
	input  logic [7:0]     cfg_data
);

	lpre_pkg::cmd_t cmd;
	lpre_pkg::sts_t sts;

	// sequence each request word
	lpre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_word.req_type),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold the levels, scale patterns, build the result word
	lpre_datapath #(
		.LED_COUNT (LED_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.res_word (res_word)
	);

endmodule

// File: tb/sv/led_pattern_register_engine_tb.sv
// ----------------------------------------------------------------------------
// led_pattern_register_engine_tb
// Self-checking bench for the LED pattern register engine. A scoreboard keeps
// its own copy of the sixteen LED levels and the max intensity, predicts the
// result word of every accepted request word, and compares each result word
// field by field in arrival order. The stimulus opens with a short directed
// run: fill extremes, all ramps, shifts, rotates, mirror, reads and unused
// codes. Random request words follow under several max intensity settings,
// including the extremes. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module led_pattern_register_engine_tb;
	import lpre_pkg::*;

	localparam int         LED_N           = 16;
	localparam int         PHASES          = 7;
	localparam int         WORDS_PER_PHASE = 250;
	localparam logic [3:0] UNUSED_LO       = REQ_READ + 4'd1;
	localparam logic [3:0] UNUSED_HI       = 4'hF;

	// ------------------------------------------------------------------
	// Scoreboard: LED level predictor plus the queue of awaited results
	// ------------------------------------------------------------------
	class lpre_board;
		logic [7:0] levels [LED_N];
		logic [7:0] intensity;
		res_t       awaited [$];
		int         fails;
		int         checked;
		int         settings;
		int         op_count [16];

		function new();
			int k;
			for (k = 0; k < LED_N; k++)
				levels[k] = 8'd0;
			for (k = 0; k < 16; k++)
				op_count[k] = 0;
			intensity = PEAK_LEVEL_RST;
			fails     = 0;
			checked   = 0;
			settings  = 0;
		endfunction

		function void set_intensity(logic [7:0] v);
			intensity = v;
			settings++;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// integer division by the LED count, truncated to a level byte
		function logic [7:0] scaled(int unsigned n);
			return 8'((n * int'(intensity)) / LED_N);
		endfunction

		// apply one request word to the level array and queue its result
		function void note_request(req_t w);
			res_t       want;
			logic [7:0] spill;
			int         k;
			want  = '0;
			spill = 8'd0;
			op_count[w.req_type]++;
			case (w.req_type)
				REQ_FILL: begin
					for (k = 0; k < LED_N; k++)
						levels[k] = w.new_level;
				end
				REQ_RAMP_UP: begin
					for (k = 0; k < LED_N; k++)
						levels[k] = scaled(k);
				end
				REQ_RAMP_DOWN: begin
					for (k = 0; k < LED_N; k++)
						levels[k] = scaled(LED_N - 1 - k);
				end
				REQ_TRIANGLE: begin
					for (k = 0; k < LED_N; k++)
						levels[k] = (k < LED_N / 2) ? scaled(2 * k)
							: scaled(2 * (LED_N - 1 - k));
				end
				REQ_ROT_R, REQ_SHIFT_R: begin
					spill = levels[LED_N - 1];
					for (k = LED_N - 1; k > 0; k--)
						levels[k] = levels[k - 1];
					if (w.req_type == REQ_ROT_R) begin
						levels[0] = spill;
					end else begin
						levels[0]        = w.new_level;
						want.shifted_out = spill;
					end
				end
				REQ_ROT_L, REQ_SHIFT_L: begin
					spill = levels[0];
					for (k = 1; k < LED_N; k++)
						levels[k - 1] = levels[k];
					if (w.req_type == REQ_ROT_L) begin
						levels[LED_N - 1] = spill;
					end else begin
						levels[LED_N - 1] = w.new_level;
						want.shifted_out  = spill;
					end
				end
				REQ_MIRROR: begin
					for (k = 0; k < LED_N / 2; k++) begin
						spill                 = levels[k];
						levels[k]             = levels[LED_N - 1 - k];
						levels[LED_N - 1 - k] = spill;
					end
				end
				REQ_READ: begin
					if (int'(w.led_index) < LED_N)
						want.read_level = levels[w.led_index];
				end
				default: begin
				end
			endcase
			want.leftmost_level  = levels[0];
			want.rightmost_level = levels[LED_N - 1];
			awaited.push_back(want);
		endfunction

		task report(string what);
			fails++;
			$display("ERROR at %0t: %s", $time, what);
		endtask

		task compare_field(string field, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("result word %0d field %s: got 0x%02h, want 0x%02h",
					checked, field, got, want));
		endtask

		task check_result(res_t got);
			res_t want;
			checked++;
			if (awaited.size() == 0) begin
				report($sformatf("result word %0d arrived with nothing awaited", checked));
			end else begin
				want = awaited.pop_front();
				compare_field("shifted_out", got.shifted_out, want.shifted_out);
				compare_field("leftmost_level", got.leftmost_level, want.leftmost_level);
				compare_field("rightmost_level", got.rightmost_level,
					want.rightmost_level);
				compare_field("read_level", got.read_level, want.read_level);
			end
		endtask
	endclass

	// ------------------------------------------------------------------
	// Clock, DUT and bench signals
	// ------------------------------------------------------------------
	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req_word;
	logic       res_valid;
	logic       res_stall;
	res_t       res_word;
	logic       cfg_we;
	logic [7:0] cfg_data;

	lpre_board  sb = new();
	int         send_calm = 0;
	int         take_calm = 0;

	always #2 clk = ~clk;

	led_pattern_register_engine #(
		.LED_COUNT(LED_N)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word (res_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// Idle draw shared by both sides: mostly a random idle gap, with the odd
	// calm stretch of back-to-back words so full-rate traffic shows up too
	// ------------------------------------------------------------------
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic req_t make_word(logic [3:0] op, logic [7:0] lvl, logic [3:0] idx);
		req_t w;
		w.req_type  = op;
		w.new_level = lvl;
		w.led_index = idx;
		return w;
	endfunction

	// Random request word. Pattern loads and shifts dominate, since they
	// are what gives the array varied contents for rotates, mirror and reads.
	function automatic req_t random_word();
		int         pick;
		logic [3:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 7)
			op = REQ_FILL;
		else if (pick < 14)
			op = REQ_RAMP_UP;
		else if (pick < 21)
			op = REQ_RAMP_DOWN;
		else if (pick < 28)
			op = REQ_TRIANGLE;
		else if (pick < 36)
			op = REQ_ROT_R;
		else if (pick < 44)
			op = REQ_ROT_L;
		else if (pick < 57)
			op = REQ_SHIFT_R;
		else if (pick < 70)
			op = REQ_SHIFT_L;
		else if (pick < 77)
			op = REQ_MIRROR;
		else if (pick < 94)
			op = REQ_READ;
		else
			op = 4'($urandom_range(UNUSED_LO, UNUSED_HI));
		return make_word(op, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
	endfunction

	// ------------------------------------------------------------------
	// Request side: idle for the drawn gap, then hold the word until taken.
	// Entered and left just after a falling edge; valid stays high across
	// back-to-back words so it is never dropped and raised in one step.
	// ------------------------------------------------------------------
	task automatic send_word(req_t w);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	// write max intensity; only called with the engine idle
	task automatic write_intensity(logic [7:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		sb.set_intensity(v);
		@(negedge clk);
		cfg_we   <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, wait for every awaited result, then let the engine drain
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pending() > 0)
			@(negedge clk);
		repeat (LED_N + 8) @(negedge clk);
	endtask

	// Directed opening: level extremes, every request code, shift-outs of
	// known values, reads at both ends and the middle, and unused codes.
	task automatic directed_run();
		send_word(make_word(REQ_READ, 8'h00, 4'd0));
		send_word(make_word(REQ_FILL, 8'hFF, 4'd0));
		send_word(make_word(REQ_READ, 8'h00, 4'd15));
		send_word(make_word(REQ_SHIFT_R, 8'hA5, 4'd0));
		send_word(make_word(REQ_SHIFT_L, 8'h5A, 4'd0));
		send_word(make_word(REQ_ROT_R, 8'h00, 4'd0));
		send_word(make_word(REQ_ROT_L, 8'h00, 4'd0));
		send_word(make_word(REQ_MIRROR, 8'h00, 4'd0));
		send_word(make_word(REQ_FILL, 8'h00, 4'hF));
		send_word(make_word(REQ_RAMP_UP, 8'h00, 4'd0));
		send_word(make_word(REQ_READ, 8'h00, 4'd7));
		send_word(make_word(REQ_MIRROR, 8'h00, 4'd0));
		send_word(make_word(REQ_READ, 8'h00, 4'd1));
		send_word(make_word(REQ_RAMP_DOWN, 8'h00, 4'd0));
		send_word(make_word(REQ_SHIFT_R, 8'h00, 4'd0));
		send_word(make_word(REQ_TRIANGLE, 8'h00, 4'd0));
		send_word(make_word(REQ_READ, 8'h00, 4'd8));
		send_word(make_word(REQ_ROT_R, 8'h00, 4'd0));
		send_word(make_word(REQ_SHIFT_L, 8'hFF, 4'd0));
		send_word(make_word(UNUSED_LO, 8'hFF, 4'hF));
		send_word(make_word(UNUSED_HI, 8'h00, 4'd0));
		send_word(make_word(REQ_READ, 8'hFF, 4'd15));
	endtask

	function automatic logic [7:0] phase_intensity(int p);
		case (p)
			0:       return PEAK_LEVEL_RST;
			1:       return 8'd1;
			2:       return 8'd0;
			3:       return 8'd128;
			4:       return 8'($urandom_range(2, 127));
			5:       return 8'($urandom_range(129, 254));
			default: return 8'd254;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sample both handshakes at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				sb.check_result(res_word);
			if (req_valid && !req_stall)
				sb.note_request(req_word);
		end
	end

	// ------------------------------------------------------------------
	// Result side: after each taken word draw a fresh stall stretch; the
	// count runs down whether or not a word is offered, so stalls land on
	// every stage of the engine's work
	// ------------------------------------------------------------------
	initial begin : result_side
		int hold;
		int seen;
		res_stall = 1'b0;
		hold      = 0;
		seen      = 0;
		forever begin
			@(negedge clk);
			if (sb.checked != seen) begin
				seen = sb.checked;
				hold = draw_wait(take_calm);
			end
			if (hold > 0) begin
				res_stall <= 1'b1;
				hold--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, then one phase per intensity setting
	// ------------------------------------------------------------------
	initial begin : stimulus
		int p;
		int n;
		int odd_codes;
		req_valid = 1'b0;
		req_word  = '0;
		cfg_we    = 1'b0;
		cfg_data  = 8'd0;
		arst_n    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (p = 0; p < PHASES; p++) begin
			write_intensity(phase_intensity(p));
			if (p == 0)
				directed_run();
			for (n = 0; n < WORDS_PER_PHASE; n++)
				send_word(random_word());
			settle();
		end

		odd_codes = 0;
		for (n = UNUSED_LO; n <= UNUSED_HI; n++)
			odd_codes += sb.op_count[n];
		$display("covered %0d intensity settings: %0d pattern loads, %0d shifts, %0d reads,",
			sb.settings, sb.op_count[REQ_RAMP_UP] + sb.op_count[REQ_RAMP_DOWN]
			+ sb.op_count[REQ_TRIANGLE], sb.op_count[REQ_SHIFT_R]
			+ sb.op_count[REQ_SHIFT_L], sb.op_count[REQ_READ]);
		$display("%0d unused codes; %0d result words compared, %0d mismatches",
			odd_codes, sb.checked, sb.fails);
		if (sb.fails == 0)
			$display("led_pattern_register_engine: match");
		else
			$display("led_pattern_register_engine: mismatch");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("timeout with %0d result words still awaited", sb.pending());
		$display("led_pattern_register_engine: mismatch");
		$finish;
	end

endmodule

// File: led_pattern_register_engine.f
rtl/core/lpre_pkg.sv
rtl/core/lpre_scaler.sv
rtl/core/lpre_datapath.sv
rtl/core/lpre_ctrl.sv
rtl/core/led_pattern_register_engine.sv
tb/sv/led_pattern_register_engine_tb.sv
